>>> rtl/scd_pkg.sv
`timescale 1ns / 1ps

package scd_pkg;

    // Sizing of the decoder
    localparam int MAX_SAMPLES   = 65536;
    localparam int CAPTURE_DEPTH = 65536;
    localparam int PROBE_COUNT   = 16;
    localparam int NAME_LEN      = 26;

    localparam int COUNT_W    = 19;
    localparam int STEP_W     = 6;
    localparam int META_LEN   = NAME_LEN + 23;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic [31:0] CAPTURE_DEPTH_WORD = 32'(CAPTURE_DEPTH);
    localparam logic [31:0] SAMPLE_RATE_WORD   = 32'd20000000;
    localparam logic [COUNT_W-1:0] MAX_COUNT   = COUNT_W'(MAX_SAMPLES);

    // Host opcodes
    localparam logic [7:0] OP_RESET     = 8'h00;
    localparam logic [7:0] OP_ARM       = 8'h01;
    localparam logic [7:0] OP_QUERY     = 8'h02;
    localparam logic [7:0] OP_SELF_TEST = 8'h03;
    localparam logic [7:0] OP_METADATA  = 8'h04;
    localparam logic [7:0] OP_TRIG_MASK = 8'hC0;
    localparam logic [7:0] OP_TRIG_VAL  = 8'hC1;
    localparam logic [7:0] OP_DIVIDER   = 8'h80;
    localparam logic [7:0] OP_COUNTS    = 8'h81;
    localparam logic [7:0] OP_FLAGS     = 8'h82;

    // Result kinds
    localparam logic [1:0] KIND_REPLY    = 2'd0;
    localparam logic [1:0] KIND_ARM      = 2'd1;
    localparam logic [1:0] KIND_SETTINGS = 2'd2;

    // Commands passed from the front to the back
    typedef enum logic [2:0] {
        CMD_ARM,
        CMD_QUERY,
        CMD_META,
        CMD_MASK,
        CMD_LEVEL,
        CMD_DIV,
        CMD_COUNTS,
        CMD_FLAGS
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] payload;
    } cmd_entry_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } bk_state_t;

    // Read or delay count: 4*(n+1), saturated
    function automatic logic [COUNT_W-1:0] count_of(input logic [15:0] n);
        logic [COUNT_W-1:0] c;
        c = {1'b0, n, 2'b00} + COUNT_W'(4);
        return (c > MAX_COUNT) ? MAX_COUNT : c;
    endfunction

    function automatic logic [7:0] query_byte(input logic [1:0] i);
        case (i)
            2'd0:    return "1";
            2'd1:    return "A";
            2'd2:    return "L";
            default: return "S";
        endcase
    endfunction

    function automatic logic [7:0] name_byte(input logic [STEP_W-1:0] i);
        case (i)
            6'd0:  return "S";  6'd1:  return "U";  6'd2:  return "M";  6'd3:  return "P";
            6'd4:  return " ";  6'd5:  return "S";  6'd6:  return "i";  6'd7:  return "x";
            6'd8:  return "t";  6'd9:  return "e";  6'd10: return "e";  6'd11: return "n";
            6'd12: return " ";  6'd13: return "C";  6'd14: return "h";  6'd15: return "a";
            6'd16: return "n";  6'd17: return "n";  6'd18: return "e";  6'd19: return "l";
            6'd20: return " ";  6'd21: return "P";  6'd22: return "r";  6'd23: return "o";
            6'd24: return "b";  6'd25: return "e";  6'd26: return " ";  6'd27: return "U";
            6'd28: return "n";  6'd29: return "i";  6'd30: return "t";  6'd31: return " ";
            6'd32: return "r";  6'd33: return "e";  6'd34: return "v";  6'd35: return " ";
            6'd36: return "0";  6'd37: return ".";  6'd38: return "1";  6'd39: return "0";
            6'd40: return "A";
            default: return 8'h00;
        endcase
    endfunction

    // Metadata reply byte at a given position
    function automatic logic [7:0] meta_byte(input logic [STEP_W-1:0] idx);
        logic [STEP_W-1:0] j;
        j = idx - STEP_W'(NAME_LEN + 1);
        if (idx == '0) begin
            return 8'h01;
        end else if (idx <= STEP_W'(NAME_LEN)) begin
            return name_byte(idx - STEP_W'(1));
        end else begin
            case (j)
                6'd0:  return 8'h00;
                6'd1:  return 8'h02;
                6'd2:  return "0";
                6'd3:  return ".";
                6'd4:  return "1";
                6'd5:  return "0";
                6'd6:  return 8'h00;
                6'd7:  return 8'h21;
                6'd8:  return CAPTURE_DEPTH_WORD[31:24];
                6'd9:  return CAPTURE_DEPTH_WORD[23:16];
                6'd10: return CAPTURE_DEPTH_WORD[15:8];
                6'd11: return CAPTURE_DEPTH_WORD[7:0];
                6'd12: return 8'h23;
                6'd13: return SAMPLE_RATE_WORD[31:24];
                6'd14: return SAMPLE_RATE_WORD[23:16];
                6'd15: return SAMPLE_RATE_WORD[15:8];
                6'd16: return SAMPLE_RATE_WORD[7:0];
                6'd17: return 8'h40;
                6'd18: return 8'(PROBE_COUNT);
                6'd19: return 8'h41;
                6'd20: return 8'h02;
                default: return 8'h00;
            endcase
        end
    endfunction

endpackage

>>> rtl/scd_front.sv
`timescale 1ns / 1ps

module scd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_valid,
    input  logic [7:0]           byte_data,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    output logic                 push,
    output scd_pkg::cmd_entry_t  push_entry
);

    logic [2:0]          payload_left_reg, payload_left_next;
    logic                pending_known_reg, pending_known_next;
    scd_pkg::cmd_t       pending_cmd_reg, pending_cmd_next;
    logic [23:0]         payload_reg, payload_next;
    logic                capture_ready_reg;

    // Capture-ready register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capture_ready_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            capture_ready_reg <= cfg_wr_data;
        end
    end

    // Classify each word: opcode, payload byte, or final payload byte
    always_comb begin
        payload_left_next  = payload_left_reg;
        pending_known_next = pending_known_reg;
        pending_cmd_next   = pending_cmd_reg;
        payload_next       = payload_reg;
        push               = 1'b0;
        push_entry.cmd     = pending_cmd_reg;
        push_entry.payload = {byte_data, payload_reg};
        if (byte_valid) begin
            if (payload_left_reg != 3'd0) begin
                if (payload_left_reg == 3'd1) begin
                    payload_left_next = 3'd0;
                    push              = pending_known_reg;
                end else begin
                    case (payload_left_reg)
                        3'd4:    payload_next[7:0]   = byte_data;
                        3'd3:    payload_next[15:8]  = byte_data;
                        default: payload_next[23:16] = byte_data;
                    endcase
                    payload_left_next = payload_left_reg - 3'd1;
                end
            end else begin
                case (byte_data)
                    scd_pkg::OP_RESET, scd_pkg::OP_SELF_TEST: begin
                    end
                    scd_pkg::OP_ARM: begin
                        push           = capture_ready_reg;
                        push_entry.cmd = scd_pkg::CMD_ARM;
                    end
                    scd_pkg::OP_QUERY: begin
                        push           = 1'b1;
                        push_entry.cmd = scd_pkg::CMD_QUERY;
                    end
                    scd_pkg::OP_METADATA: begin
                        push           = 1'b1;
                        push_entry.cmd = scd_pkg::CMD_META;
                    end
                    default: begin
                        payload_left_next  = 3'd4;
                        pending_known_next = 1'b1;
                        case (byte_data)
                            scd_pkg::OP_TRIG_MASK: pending_cmd_next = scd_pkg::CMD_MASK;
                            scd_pkg::OP_TRIG_VAL:  pending_cmd_next = scd_pkg::CMD_LEVEL;
                            scd_pkg::OP_DIVIDER:   pending_cmd_next = scd_pkg::CMD_DIV;
                            scd_pkg::OP_COUNTS:    pending_cmd_next = scd_pkg::CMD_COUNTS;
                            scd_pkg::OP_FLAGS:     pending_cmd_next = scd_pkg::CMD_FLAGS;
                            default:               pending_known_next = 1'b0;
                        endcase
                    end
                endcase
            end
        end
    end

    // Hold decode state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_left_reg  <= 3'd0;
            pending_known_reg <= 1'b0;
            pending_cmd_reg   <= scd_pkg::CMD_ARM;
        end else begin
            payload_left_reg  <= payload_left_next;
            pending_known_reg <= pending_known_next;
            pending_cmd_reg   <= pending_cmd_next;
        end
    end

    always_ff @(posedge aclk) begin
        payload_reg <= payload_next;
    end

endmodule

>>> rtl/scd_queue.sv
`timescale 1ns / 1ps

module scd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  scd_pkg::cmd_entry_t  push_entry,
    input  logic                 pop,
    output scd_pkg::cmd_entry_t  head_entry,
    output logic                 full,
    output logic                 empty
);

    scd_pkg::cmd_entry_t             entry_reg [scd_pkg::QUEUE_DEPTH];
    logic [scd_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [scd_pkg::QCNT_W-1:0]      count_reg;

    assign full       = (count_reg == scd_pkg::QCNT_W'(scd_pkg::QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign head_entry = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + scd_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + scd_pkg::QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + scd_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - scd_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/scd_back.sv
`timescale 1ns / 1ps

module scd_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_empty,
    input  scd_pkg::cmd_entry_t                 q_head,
    output logic                                pop,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [1:0]                          res_kind,
    output logic [7:0]                          res_tx_byte,
    output logic                                res_last,
    output logic [15:0]                         trig_mask,
    output logic [15:0]                         trig_value,
    output logic [23:0]                         sample_divider,
    output logic [scd_pkg::COUNT_W-1:0]         read_samples,
    output logic [scd_pkg::COUNT_W-1:0]         delay_samples,
    output logic                                rle_on,
    output logic [3:0]                          group_enable
);

    scd_pkg::bk_state_t              state_reg, state_next;
    scd_pkg::cmd_t                   cmd_reg;
    logic [31:0]                     arg_reg;
    logic [scd_pkg::STEP_W-1:0]      step_reg;
    logic                            valid_reg;
    logic [1:0]                      kind_reg, kind_next;
    logic [7:0]                      tx_reg, tx_next;
    logic                            last_reg, last_next;
    logic                            emit;
    logic                            slot_free;
    logic [15:0]                     mask_reg;
    logic [15:0]                     level_reg;
    logic [23:0]                     divider_reg;
    logic [scd_pkg::COUNT_W-1:0]     read_count_reg, delay_count_reg;
    logic                            rle_reg;
    logic [3:0]                      groups_reg;

    assign slot_free = !valid_reg || res_ready;

    // Next state and per-step result
    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        kind_next  = scd_pkg::KIND_SETTINGS;
        tx_next    = 8'h00;
        last_next  = 1'b1;
        case (cmd_reg)
            scd_pkg::CMD_ARM: begin
                kind_next = scd_pkg::KIND_ARM;
            end
            scd_pkg::CMD_QUERY: begin
                kind_next = scd_pkg::KIND_REPLY;
                tx_next   = scd_pkg::query_byte(step_reg[1:0]);
                last_next = (step_reg == scd_pkg::STEP_W'(3));
            end
            scd_pkg::CMD_META: begin
                kind_next = scd_pkg::KIND_REPLY;
                tx_next   = scd_pkg::meta_byte(step_reg);
                last_next = (step_reg == scd_pkg::STEP_W'(scd_pkg::META_LEN - 1));
            end
            default: begin
            end
        endcase
        case (state_reg)
            scd_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    pop        = 1'b1;
                    state_next = scd_pkg::BK_RUN;
                end
            end
            scd_pkg::BK_RUN: begin
                if (slot_free) begin
                    emit = 1'b1;
                    if (last_next) begin
                        state_next = scd_pkg::BK_IDLE;
                    end
                end
            end
            default: state_next = scd_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scd_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Load the command and step through its results
    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg  <= q_head.cmd;
            arg_reg  <= q_head.payload;
            step_reg <= '0;
        end else if (emit) begin
            step_reg <= step_reg + scd_pkg::STEP_W'(1);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (emit) begin
            valid_reg <= 1'b1;
        end else if (res_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg <= kind_next;
            tx_reg   <= tx_next;
            last_reg <= last_next;
        end
    end

    // Apply a setting as its result is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg        <= '0;
            level_reg       <= '0;
            divider_reg     <= '0;
            read_count_reg  <= '0;
            delay_count_reg <= '0;
            rle_reg         <= 1'b0;
            groups_reg      <= 4'd3;
        end else if (emit) begin
            case (cmd_reg)
                scd_pkg::CMD_MASK:  mask_reg    <= arg_reg[15:0];
                scd_pkg::CMD_LEVEL: level_reg   <= arg_reg[15:0];
                scd_pkg::CMD_DIV:   divider_reg <= arg_reg[23:0];
                scd_pkg::CMD_COUNTS: begin
                    read_count_reg  <= scd_pkg::count_of(arg_reg[15:0]);
                    delay_count_reg <= scd_pkg::count_of(arg_reg[31:16]);
                end
                scd_pkg::CMD_FLAGS: begin
                    rle_reg    <= arg_reg[8];
                    groups_reg <= ~arg_reg[5:2];
                end
                default: begin
                end
            endcase
        end
    end

    assign res_valid      = valid_reg;
    assign res_kind       = kind_reg;
    assign res_tx_byte    = tx_reg;
    assign res_last       = last_reg;
    assign trig_mask      = mask_reg;
    assign trig_value     = level_reg;
    assign sample_divider = divider_reg;
    assign read_samples   = read_count_reg;
    assign delay_samples  = delay_count_reg;
    assign rle_on         = rle_reg;
    assign group_enable   = groups_reg;

endmodule

>>> rtl/sump_command_decoder.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Contents
// s_        in         s_tvalid/s_tready   host byte
// m_        out        m_tvalid/m_tready   result: kind, reply byte, current settings
// cfg_      in         cfg_wr_en           capture_ready
//
// One host byte is accepted per cycle while the four-entry command queue has room.
// The back end emits one result per cycle while the m_ side is ready, and returns to its
// idle state between commands. Results: query 4, metadata NAME_LEN + 23, arm/settings 1.
// Reset is synchronous, active low; settings return to zero with groups 0 and 1 on.
// A stalled m_ side fills the queue, then holds s_tready low.

module sump_command_decoder (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // [7:0] tx_byte, [23:8] trig_mask, [39:24] trig_value,
                                    // [63:40] sample_divider, [82:64] read_samples,
                                    // [101:83] delay_samples, [102] rle_on,
                                    // [106:103] group_enable, rest zero
    output logic [1:0]   m_tuser,   // [1:0] kind
    output logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data
);

    logic                             q_full, q_empty, push, pop;
    scd_pkg::cmd_entry_t              push_entry, head_entry;
    logic [7:0]                       tx_byte;
    logic [15:0]                      trig_mask, trig_value;
    logic [23:0]                      sample_divider;
    logic [scd_pkg::COUNT_W-1:0]      read_samples, delay_samples;
    logic                             rle_on;
    logic [3:0]                       group_enable;

    assign s_tready = !q_full;

    scd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_valid  (s_tvalid && !q_full),
        .byte_data   (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .push_entry  (push_entry)
    );

    scd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    scd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_head         (head_entry),
        .pop            (pop),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .res_kind       (m_tuser),
        .res_tx_byte    (tx_byte),
        .res_last       (m_tlast),
        .trig_mask      (trig_mask),
        .trig_value     (trig_value),
        .sample_divider (sample_divider),
        .read_samples   (read_samples),
        .delay_samples  (delay_samples),
        .rle_on         (rle_on),
        .group_enable   (group_enable)
    );

    // Pack the result word
    assign m_tdata = {5'b0, group_enable, rle_on, delay_samples, read_samples,
                      sample_divider, trig_value, trig_mask, tx_byte};

endmodule

>>> tb/sv/sump_command_decoder_tb.sv
`timescale 1ns / 1ps

module sump_command_decoder_tb;

    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 27;
    localparam int MAX_REPLIES    = 49;

    // Opcode with no meaning to the decoder: takes a payload, changes nothing
    localparam logic [7:0] UNLISTED_OP = 8'h05;

    // Metadata tags
    localparam logic [7:0] META_END      = 8'h00;
    localparam logic [7:0] META_NAME     = 8'h01;
    localparam logic [7:0] META_VERSION  = 8'h02;
    localparam logic [7:0] META_DEPTH    = 8'h21;
    localparam logic [7:0] META_RATE     = 8'h23;
    localparam logic [7:0] META_PROBES   = 8'h40;
    localparam logic [7:0] META_PROTOCOL = 8'h41;
    localparam logic [7:0] PROTOCOL_VER  = 8'h02;
    localparam logic [31:0] RATE_HZ      = 32'd20000000;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic        last;
        logic [15:0] mask;
        logic [15:0] level;
        logic [23:0] divider;
        logic [18:0] read_cnt;
        logic [18:0] delay_cnt;
        logic        rle;
        logic [3:0]  groups;
    } reply_t;

    // Tracks decoder state and the replies each host byte should produce
    class reply_tracker;
        reply_t      pending_replies[$];
        reply_t      this_byte[$];
        int unsigned mismatches;
        bit          capture_ready;
        logic [2:0]  payload_left;
        logic [7:0]  pending_op;
        logic [23:0] payload_bytes;
        logic [15:0] mask;
        logic [15:0] level;
        logic [23:0] divider;
        logic [18:0] read_cnt;
        logic [18:0] delay_cnt;
        logic        rle;
        logic [3:0]  groups;

        function new();
            mismatches    = 0;
            capture_ready = 1'b0;
            payload_left  = '0;
            pending_op    = '0;
            payload_bytes = '0;
            mask          = '0;
            level         = '0;
            divider       = '0;
            read_cnt      = '0;
            delay_cnt     = '0;
            rle           = 1'b0;
            groups        = 4'd3;
        endfunction

        // Queue one reply carrying the current settings
        function void push(logic [1:0] kind, logic [7:0] tx);
            reply_t r;
            if (this_byte.size() >= MAX_REPLIES) return;
            r.kind      = kind;
            r.tx        = tx;
            r.last      = 1'b0;
            r.mask      = mask;
            r.level     = level;
            r.divider   = divider;
            r.read_cnt  = read_cnt;
            r.delay_cnt = delay_cnt;
            r.rle       = rle;
            r.groups    = groups;
            this_byte.push_back(r);
        endfunction

        // Most significant byte first
        function void push_word(logic [31:0] w);
            for (int i = 3; i >= 0; i--) push(scd_pkg::KIND_REPLY, w[8*i +: 8]);
        endfunction

        static function logic [18:0] sample_count(logic [15:0] n);
            int unsigned c;
            c = (32'(n) + 1) * 4;
            if (c > scd_pkg::MAX_SAMPLES) c = scd_pkg::MAX_SAMPLES;
            return 19'(c);
        endfunction

        function void send_metadata();
            string dev_name;
            string fw;
            dev_name = "SUMP Sixteen Channel Probe Unit rev 0.10A";
            fw       = "0.10";
            push(scd_pkg::KIND_REPLY, META_NAME);
            for (int i = 0; i < scd_pkg::NAME_LEN && i < dev_name.len(); i++)
                push(scd_pkg::KIND_REPLY, dev_name[i]);
            push(scd_pkg::KIND_REPLY, META_END);
            push(scd_pkg::KIND_REPLY, META_VERSION);
            for (int i = 0; i < fw.len(); i++) push(scd_pkg::KIND_REPLY, fw[i]);
            push(scd_pkg::KIND_REPLY, META_END);
            push(scd_pkg::KIND_REPLY, META_DEPTH);
            push_word(32'(scd_pkg::CAPTURE_DEPTH));
            push(scd_pkg::KIND_REPLY, META_RATE);
            push_word(RATE_HZ);
            push(scd_pkg::KIND_REPLY, META_PROBES);
            push(scd_pkg::KIND_REPLY, 8'(scd_pkg::PROBE_COUNT));
            push(scd_pkg::KIND_REPLY, META_PROTOCOL);
            push(scd_pkg::KIND_REPLY, PROTOCOL_VER);
            push(scd_pkg::KIND_REPLY, META_END);
        endfunction

        // Fourth payload byte arrived: apply the pending long command
        function void apply_command(logic [7:0] b3);
            case (pending_op)
                scd_pkg::OP_TRIG_MASK: begin
                    mask = payload_bytes[15:0];
                    push(scd_pkg::KIND_SETTINGS, 8'h00);
                end
                scd_pkg::OP_TRIG_VAL: begin
                    level = payload_bytes[15:0];
                    push(scd_pkg::KIND_SETTINGS, 8'h00);
                end
                scd_pkg::OP_DIVIDER: begin
                    divider = payload_bytes;
                    push(scd_pkg::KIND_SETTINGS, 8'h00);
                end
                scd_pkg::OP_COUNTS: begin
                    read_cnt  = sample_count(payload_bytes[15:0]);
                    delay_cnt = sample_count({b3, payload_bytes[23:16]});
                    push(scd_pkg::KIND_SETTINGS, 8'h00);
                end
                scd_pkg::OP_FLAGS: begin
                    rle    = payload_bytes[8];
                    groups = ~payload_bytes[5:2];
                    push(scd_pkg::KIND_SETTINGS, 8'h00);
                end
                default: ;
            endcase
        endfunction

        // Note one accepted host byte and queue the replies it causes
        function void take_host_byte(logic [7:0] b);
            int    pos;
            string query_reply;
            query_reply = "1ALS";
            this_byte.delete();
            if (payload_left != 0) begin
                if (payload_left == 3'd1) begin
                    payload_left = '0;
                    apply_command(b);
                end else begin
                    pos = 4 - int'(payload_left);
                    payload_bytes[8*pos +: 8] = b;
                    payload_left--;
                end
            end else begin
                case (b)
                    scd_pkg::OP_RESET, scd_pkg::OP_SELF_TEST: ;
                    scd_pkg::OP_ARM: if (capture_ready) push(scd_pkg::KIND_ARM, 8'h00);
                    scd_pkg::OP_QUERY: begin
                        for (int i = 0; i < 4; i++) push(scd_pkg::KIND_REPLY, query_reply[i]);
                    end
                    scd_pkg::OP_METADATA: send_metadata();
                    default: begin
                        pending_op   = b;
                        payload_left = 3'd4;
                    end
                endcase
            end
            if (this_byte.size() != 0) this_byte[$].last = 1'b1;
            foreach (this_byte[i]) pending_replies.push_back(this_byte[i]);
        endfunction

        task report(string msg);
            $display("[%0t] %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        // Compare one accepted result word with the oldest expected reply
        task check_reply(logic [1:0] kind, logic [111:0] data, logic last);
            reply_t want;
            if (pending_replies.size() == 0) begin
                report($sformatf("result with nothing expected: kind %0d byte 0x%02h",
                                 kind, data[7:0]));
                return;
            end
            want = pending_replies.pop_front();
            compare_field("kind", kind, want.kind);
            compare_field("tx_byte", data[7:0], want.tx);
            compare_field("last", last, want.last);
            compare_field("trig_mask", data[23:8], want.mask);
            compare_field("trig_value", data[39:24], want.level);
            compare_field("sample_divider", data[63:40], want.divider);
            compare_field("read_samples", data[82:64], want.read_cnt);
            compare_field("delay_samples", data[101:83], want.delay_cnt);
            compare_field("rle_on", data[102], want.rle);
            compare_field("group_enable", data[106:103], want.groups);
        endtask
    endclass

    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         s_tvalid    = 1'b0;
    logic [7:0]   s_tdata     = '0;
    logic         m_tready    = 1'b0;
    logic         cfg_wr_en   = 1'b0;
    logic         cfg_wr_data = 1'b0;
    logic         s_tready;
    logic         m_tvalid;
    logic [111:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    reply_tracker book = new();
    int burst_left = 0;
    int items_sent = 0;
    bit hold_req   = 1'b0;

    sump_command_decoder u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Check every accepted result word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.check_reply(m_tuser, m_tdata, m_tlast);
    end

    // Stall the result side in stretches; hold off completely on request
    initial begin : receiver
        int mode_left;
        int stall_pct;
        mode_left = 0;
        stall_pct = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (mode_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    default: stall_pct = 75;
                endcase
                mode_left = $urandom_range(8, 40);
            end
            mode_left--;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[sump_command_decoder] ERROR");
        $finish;
    end

    // Offer one host byte in bursts with random gaps; return once accepted
    task automatic send_byte(logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.take_host_byte(b);
        burst_left--;
        items_sent++;
    endtask

    // Payload bytes lean toward the edges of the count and mask ranges
    function automatic logic [7:0] payload_value();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h3F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed commands with random payload, some stray bytes
    task automatic send_command();
        int         pick;
        logic [7:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            send_byte(scd_pkg::OP_METADATA);
        end else if (pick < 18) begin
            case ($urandom_range(0, 3))
                0:       send_byte(scd_pkg::OP_RESET);
                1:       send_byte(scd_pkg::OP_ARM);
                2:       send_byte(scd_pkg::OP_QUERY);
                default: send_byte(scd_pkg::OP_SELF_TEST);
            endcase
        end else if (pick < 92) begin
            if (pick < 82) begin
                case ($urandom_range(0, 4))
                    0:       op = scd_pkg::OP_TRIG_MASK;
                    1:       op = scd_pkg::OP_TRIG_VAL;
                    2:       op = scd_pkg::OP_DIVIDER;
                    3:       op = scd_pkg::OP_COUNTS;
                    default: op = scd_pkg::OP_FLAGS;
                endcase
            end else begin
                op = 8'($urandom_range(5, 255));
            end
            send_byte(op);
            repeat (4) send_byte(payload_value());
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Stop offering, drain every expected reply, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (book.pending_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capture_ready(bit v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        book.capture_ready = v;
    endtask

    initial begin : stimulus
        logic [7:0] not_ready_bytes[] = '{scd_pkg::OP_ARM, scd_pkg::OP_RESET,
                                          scd_pkg::OP_SELF_TEST, scd_pkg::OP_QUERY,
                                          scd_pkg::OP_METADATA};
        logic [7:0] ready_bytes[] = '{
            scd_pkg::OP_ARM,
            scd_pkg::OP_COUNTS, 8'hFF, 8'hFF, 8'h00, 8'h00,
            scd_pkg::OP_FLAGS, 8'h00, 8'h01, 8'hFF, 8'hFF,
            scd_pkg::OP_DIVIDER, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            UNLISTED_OP, scd_pkg::OP_QUERY, scd_pkg::OP_METADATA, scd_pkg::OP_ARM,
            scd_pkg::OP_RESET
        };
        int target;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Short opcodes with the backend not ready: arm must stay silent
        set_capture_ready(1'b0);
        foreach (not_ready_bytes[i]) send_byte(not_ready_bytes[i]);

        // Arm, saturating counts, flags, full divider, opcode-like payload bytes
        set_capture_ready(1'b1);
        foreach (ready_bytes[i]) send_byte(ready_bytes[i]);

        // Random phases; the first starts with a long result-side hold-off
        for (int phase = 0; phase < 3; phase++) begin
            set_capture_ready(phase != 1);
            if (phase == 0) hold_req = 1'b1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) send_command();
        end

        wait_idle();
        if (book.mismatches == 0 && book.pending_replies.size() == 0) begin
            $display("[sump_command_decoder] OK");
        end else begin
            $display("[sump_command_decoder] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/scd_pkg.sv
rtl/scd_front.sv
rtl/scd_queue.sv
rtl/scd_back.sv
rtl/sump_command_decoder.sv
tb/sv/sump_command_decoder_tb.sv
